// ===== rtl/core/nmsr_pkg.sv =====
package nmsr_pkg;

  localparam int MAX_SIDE_LOG2   = 8;
  localparam int COORD_FRAC_BITS = 16;
  localparam int COEF_FRAC_BITS  = 14;

  localparam int ADDR_W     = 16;
  localparam int TEXEL_W    = 24;
  localparam int LOG2_W     = 4;
  localparam int COORD_W    = 24;
  localparam int ROW_W      = 48;
  localparam int COEF_W     = 16;
  localparam int CHAN_W     = 8;
  localparam int NORM_W     = 16;
  localparam int PROD_W     = 2 * COEF_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int S_W        = 18;
  localparam int MAG_W      = S_W - 1;
  localparam int SQ_W       = 2 * S_W;
  localparam int SUMSQ_W    = 35;
  localparam int NORM_SHIFT = 28;
  localparam int ROOT_W     = 32;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int QUO_W      = 16;
  localparam int DREM_W     = 48;
  localparam int ONE_Q14    = 16384;
  localparam int LUT_DEPTH  = 1 << CHAN_W;

  typedef enum logic [1:0] {
    CFG_MAP_ENABLED = 2'd0,
    CFG_WIDTH_LOG2  = 2'd1,
    CFG_HEIGHT_LOG2 = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_t;

  typedef struct packed {
    logic                func;
    logic [COORD_W-1:0]  coord_u;
    logic [COORD_W-1:0]  coord_v;
    logic [ADDR_W-1:0]   texel_addr;
    logic [TEXEL_W-1:0]  texel_rgb;
    logic [ROW_W-1:0]    rot_row0;
    logic [ROW_W-1:0]    rot_row1;
    logic [ROW_W-1:0]    rot_row2;
  } req_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     degenerate;
  } rsp_t;

  typedef struct packed {
    logic vld;
    logic dis;
    logic degen;
  } tag_t;

  typedef logic signed [NORM_W-1:0] dec_lut_t [LUT_DEPTH];

  function automatic dec_lut_t build_dec_lut();
    dec_lut_t lut;
    int n;
    int mag;
    int q;
    for (int c = 0; c < LUT_DEPTH; c++) begin
      n = (2 * c - 255) * ONE_Q14;
      mag = (n < 0) ? -n : n;
      q = (mag + 127) / 255;
      lut[c] = NORM_W'((n < 0) ? -q : q);
    end
    return lut;
  endfunction

  localparam dec_lut_t DEC_LUT = build_dec_lut();

endpackage

// ===== rtl/core/normal_map_sample_rotate_top.sv =====
// Tangent-space normal map sampler. Write transactions (func 0) store one
// texel; lookup transactions (func 1) return one unit normal each, in order
// (all zero while the map is disabled; flagged degenerate for a zero vector).
// One transaction is taken per cycle whenever the result register is free or
// being drained; a lookup passes through the texel read, the four-stage
// decode/rotate/square path, the 32-stage bit-per-stage square root, the
// 16-stage quotient pipeline and the result register. A lookup issued right
// after a write to the same texel sees the new texel. Change the
// configuration registers only when no lookup is in flight.
module normal_map_sample_rotate_top
  import nmsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [LOG2_W-1:0] cfg_data
);

  logic               map_enabled;
  logic [LOG2_W-1:0]  width_log2;
  logic [LOG2_W-1:0]  height_log2;
  logic               en;
  logic               accept;
  tag_t               tag1;
  logic [ROW_W-1:0]   rows [3];
  logic [TEXEL_W-1:0] rgb;
  tag_t               rot_tag;
  logic signed [S_W-1:0] s [3];
  logic [SUMSQ_W-1:0] sumsq;
  tag_t               nrm_tag;
  rsp_t               nrm_rsp;

  assign en = !rsp_valid || !rsp_stall;
  assign req_stall = !en;
  assign accept = req_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_enabled <= 1'b0;
      width_log2 <= LOG2_W'(8);
      height_log2 <= LOG2_W'(8);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAP_ENABLED: map_enabled <= cfg_data[0];
        CFG_WIDTH_LOG2:  width_log2 <= cfg_data;
        CFG_HEIGHT_LOG2: height_log2 <= cfg_data;
        default: ;
      endcase
    end
  end

  nmsr_texmem u_texmem (
    .clk         (clk),
    .en          (en),
    .we          (accept && (req.func == FUNC_WRITE)),
    .waddr       (req.texel_addr),
    .wdata       (req.texel_rgb),
    .coord_u     (req.coord_u),
    .coord_v     (req.coord_v),
    .width_log2  (width_log2),
    .height_log2 (height_log2),
    .rdata       (rgb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
    end else if (en) begin
      tag1 <= '{vld: accept && (req.func == FUNC_LOOKUP), dis: !map_enabled, degen: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rows[0] <= req.rot_row0;
      rows[1] <= req.rot_row1;
      rows[2] <= req.rot_row2;
    end
  end

  nmsr_rotate u_rotate (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag_in  (tag1),
    .rgb     (rgb),
    .rows    (rows),
    .tag_out (rot_tag),
    .s_out   (s),
    .sumsq   (sumsq)
  );

  nmsr_norm u_norm (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag_in  (rot_tag),
    .s_in    (s),
    .sumsq   (sumsq),
    .tag_out (nrm_tag),
    .rsp     (nrm_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= nrm_tag.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= nrm_rsp;
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.degenerate |->
      rsp.normal_x == '0 && rsp.normal_y == '0 && rsp.normal_z == '0)
    else $error("degenerate result with nonzero normal");

  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |->
      rsp.normal_x <= NORM_W'(ONE_Q14) && rsp.normal_x >= -NORM_W'(ONE_Q14) &&
      rsp.normal_y <= NORM_W'(ONE_Q14) && rsp.normal_y >= -NORM_W'(ONE_Q14) &&
      rsp.normal_z <= NORM_W'(ONE_Q14) && rsp.normal_z >= -NORM_W'(ONE_Q14))
    else $error("normal component out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

endmodule

// ===== rtl/core/nmsr_texmem.sv =====
module nmsr_texmem
  import nmsr_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [TEXEL_W-1:0] wdata,
  input  logic [COORD_W-1:0] coord_u,
  input  logic [COORD_W-1:0] coord_v,
  input  logic [LOG2_W-1:0]  width_log2,
  input  logic [LOG2_W-1:0]  height_log2,
  output logic [TEXEL_W-1:0] rdata
);

  logic [TEXEL_W-1:0] mem [1 << ADDR_W];

  logic [LOG2_W-1:0]  wl;
  logic [LOG2_W-1:0]  hl;
  logic [31:0]        ush;
  logic [31:0]        vsh;
  logic [ADDR_W-1:0]  wmask;
  logic [ADDR_W-1:0]  hmask;
  logic [ADDR_W-1:0]  col;
  logic [ADDR_W-1:0]  vrow;
  logic [ADDR_W-1:0]  row;
  logic [ADDR_W-1:0]  raddr;

  always_comb begin
    wl = (width_log2 > LOG2_W'(MAX_SIDE_LOG2)) ? LOG2_W'(MAX_SIDE_LOG2) : width_log2;
    hl = (height_log2 > LOG2_W'(MAX_SIDE_LOG2)) ? LOG2_W'(MAX_SIDE_LOG2) : height_log2;
    ush = 32'(coord_u) << wl;
    vsh = 32'(coord_v) << hl;
    wmask = (ADDR_W'(1) << wl) - ADDR_W'(1);
    hmask = (ADDR_W'(1) << hl) - ADDR_W'(1);
    col = ADDR_W'(ush >> COORD_FRAC_BITS) & wmask;
    vrow = ADDR_W'(vsh >> COORD_FRAC_BITS) & hmask;
    row = hmask - vrow;
    raddr = (row << wl) + col;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/nmsr_rotate.sv =====
module nmsr_rotate
  import nmsr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  tag_t                     tag_in,
  input  logic [TEXEL_W-1:0]       rgb,
  input  logic [ROW_W-1:0]         rows [3],
  output tag_t                     tag_out,
  output logic signed [S_W-1:0]    s_out [3],
  output logic [SUMSQ_W-1:0]       sumsq
);

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

  logic signed [COEF_W-1:0] coef [3][3];
  logic signed [NORM_W-1:0] n [3];
  logic signed [ACC_W-1:0]  acc [3];
  logic signed [PROD_W-1:0] p [3][3];
  logic signed [S_W-1:0]    s2 [3];
  logic signed [S_W-1:0]    s3 [3];
  logic signed [SQ_W-1:0]   sq [3];
  tag_t                     t2, t3, t4, t5;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n[i] = DEC_LUT[rgb[TEXEL_W-1-CHAN_W*i -: CHAN_W]];
      for (int j = 0; j < 3; j++) begin
        coef[i][j] = rows[i][ROW_W-1-COEF_W*j -: COEF_W];
      end
      acc[i] = ACC_W'(p[i][0]) + ACC_W'(p[i][1]) + ACC_W'(p[i][2]) + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t2 <= '0;
      t3 <= '0;
      t4 <= '0;
      t5 <= '0;
    end else if (en) begin
      t2 <= tag_in;
      t3 <= t2;
      t4 <= t3;
      t5 <= t4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p[i][j] <= coef[i][j] * n[j];
        end
        s2[i] <= S_W'(acc[i] >>> COEF_FRAC_BITS);
        s3[i] <= s2[i];
        sq[i] <= s2[i] * s2[i];
        s_out[i] <= s3[i];
      end
      sumsq <= SUMSQ_W'(sq[0] + sq[1] + sq[2]);
    end
  end

  assign tag_out = t5;

endmodule

// ===== rtl/core/nmsr_norm.sv =====
module nmsr_norm
  import nmsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  tag_t                  tag_in,
  input  logic signed [S_W-1:0] s_in [3],
  input  logic [SUMSQ_W-1:0]    sumsq,
  output tag_t                  tag_out,
  output rsp_t                  rsp
);

  logic [ROOT_W-1:0] rt  [ROOT_W+1];
  logic [RAD_W-1:0]  rm  [ROOT_W+1];
  tag_t              tg  [ROOT_W+1];
  logic [MAG_W-1:0]  mg  [ROOT_W+1][3];
  logic              sg  [ROOT_W+1][3];

  logic [ROOT_W-1:0] dv  [QUO_W+1];
  logic [DREM_W-1:0] dr  [QUO_W+1][3];
  logic [QUO_W-1:0]  qq  [QUO_W+1][3];
  tag_t              dtg [QUO_W+1];
  logic              dsg [QUO_W+1][3];

  logic [QUO_W-1:0]         qc [3];
  logic signed [NORM_W-1:0] nv [3];

  always_comb begin
    rt[0] = '0;
    rm[0] = RAD_W'(sumsq) << NORM_SHIFT;
    tg[0] = '{vld: tag_in.vld, dis: tag_in.dis, degen: (sumsq == '0)};
    for (int i = 0; i < 3; i++) begin
      sg[0][i] = s_in[i][S_W-1];
      mg[0][i] = MAG_W'(s_in[i][S_W-1] ? -s_in[i] : s_in[i]);
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - k;
    logic [RAD_W-1:0] trial;
    assign trial = (RAD_W'(rt[k]) << (B + 1)) | (RAD_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        tg[k+1] <= '0;
      end else if (en) begin
        tg[k+1] <= tg[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rm[k] >= trial) begin
          rm[k+1] <= rm[k] - trial;
          rt[k+1] <= rt[k] | (ROOT_W'(1) << B);
        end else begin
          rm[k+1] <= rm[k];
          rt[k+1] <= rt[k];
        end
        for (int i = 0; i < 3; i++) begin
          mg[k+1][i] <= mg[k][i];
          sg[k+1][i] <= sg[k][i];
        end
      end
    end
  end

  always_comb begin
    dv[0] = rt[ROOT_W];
    dtg[0] = tg[ROOT_W];
    for (int i = 0; i < 3; i++) begin
      dr[0][i] = (DREM_W'(mg[ROOT_W][i]) << NORM_SHIFT) + DREM_W'(rt[ROOT_W] >> 1);
      qq[0][i] = '0;
      dsg[0][i] = sg[ROOT_W][i];
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    localparam int B = QUO_W - 1 - k;
    logic [DREM_W-1:0] dsh;
    assign dsh = DREM_W'(dv[k]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        dtg[k+1] <= '0;
      end else if (en) begin
        dtg[k+1] <= dtg[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1] <= dv[k];
        for (int i = 0; i < 3; i++) begin
          dsg[k+1][i] <= dsg[k][i];
          if (dr[k][i] >= dsh) begin
            dr[k+1][i] <= dr[k][i] - dsh;
            qq[k+1][i] <= qq[k][i] | (QUO_W'(1) << B);
          end else begin
            dr[k+1][i] <= dr[k][i];
            qq[k+1][i] <= qq[k][i];
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (qq[QUO_W][i] > QUO_W'(ONE_Q14)) ? QUO_W'(ONE_Q14) : qq[QUO_W][i];
      nv[i] = dsg[QUO_W][i] ? -$signed(qc[i]) : $signed(qc[i]);
    end
    rsp = '0;
    if (!dtg[QUO_W].dis) begin
      if (dtg[QUO_W].degen) begin
        rsp.degenerate = 1'b1;
      end else begin
        rsp.normal_x = nv[0];
        rsp.normal_y = nv[1];
        rsp.normal_z = nv[2];
      end
    end
  end

  assign tag_out = dtg[QUO_W];

endmodule

// ===== test/normal_map_sample_rotate_top_tb.sv =====
module normal_map_sample_rotate_top_tb
  import nmsr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD = 400;
  localparam int REQ_W = $bits(req_t);

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    req_t r;
    bit typed;
    rsp_t e;
    logic [3:0] en, wl, hl;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_MAP_ENABLED;
  logic [LOG2_W-1:0] cfg_data = '0;

  bit map_on = 1'b0;
  int width_reg = 8;
  int height_reg = 8;
  logic [TEXEL_W-1:0] texel_mirror [int];
  rsp_t normal_q [$];

  int snd_idle_pct = 20;
  int rcv_idle_pct = 86;
  bit long_hold = 1'b0;
  bit hold_used = 1'b0;
  int hold_cnt = 0;
  int errors = 0;
  int n_items = 0;
  int n_normals = 0;
  int n_degen = 0;
  int n_config = 0;

  always #2 clk = ~clk;

  normal_map_sample_rotate_top uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic int side_log2(int v);
    return (v > MAX_SIDE_LOG2) ? MAX_SIDE_LOG2 : v;
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic rsp_t predict_normal(req_t r);
    rsp_t o;
    int wl, hl;
    longint col, vrow, row, addr;
    logic [TEXEL_W-1:0] rgb;
    longint n [3];
    longint s [3];
    longint acc, t, c, mag, q;
    longint unsigned sum, d, um;
    logic [ROW_W-1:0] rows [3];
    o = '0;
    if (!map_on) return o;
    wl = side_log2(width_reg);
    hl = side_log2(height_reg);
    col = ((longint'(r.coord_u) << wl) >> COORD_FRAC_BITS) & ((64'd1 << wl) - 1);
    vrow = ((longint'(r.coord_v) << hl) >> COORD_FRAC_BITS) & ((64'd1 << hl) - 1);
    row = ((64'd1 << hl) - 1) - vrow;
    addr = ((row << wl) + col) & 16'hFFFF;
    rgb = texel_mirror.exists(int'(addr)) ? texel_mirror[int'(addr)] : '0;
    for (int j = 0; j < 3; j++) begin
      c = rgb[23-8*j -: 8];
      t = (2 * c - 255) * ONE_Q14;
      mag = (t < 0) ? -t : t;
      q = (mag + 127) / 255;
      n[j] = (t < 0) ? -q : q;
    end
    rows[0] = r.rot_row0;
    rows[1] = r.rot_row1;
    rows[2] = r.rot_row2;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++)
        acc += longint'($signed(rows[i][47-16*j -: 16])) * n[j];
      t = acc + (64'sd1 <<< (COEF_FRAC_BITS - 1));
      if (t >= 0) s[i] = t / (64'sd1 <<< COEF_FRAC_BITS);
      else s[i] = -((-t + (64'sd1 <<< COEF_FRAC_BITS) - 1) / (64'sd1 <<< COEF_FRAC_BITS));
      sum += longint'(s[i] * s[i]);
    end
    if (sum == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    d = root64(sum << NORM_SHIFT);
    for (int i = 0; i < 3; i++) begin
      um = (s[i] < 0) ? -s[i] : s[i];
      um = ((um << NORM_SHIFT) + d / 2) / d;
      if (um > ONE_Q14) um = ONE_Q14;
      s[i] = (s[i] < 0) ? -longint'(um) : longint'(um);
    end
    o.normal_x = NORM_W'(s[0]);
    o.normal_y = NORM_W'(s[1]);
    o.normal_z = NORM_W'(s[2]);
    return o;
  endfunction

  function automatic req_t mk_write(int addr, logic [TEXEL_W-1:0] rgb);
    req_t r;
    r = req_t'(REQ_W'({$urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom}));
    r.func = FUNC_WRITE;
    r.texel_addr = addr[15:0];
    r.texel_rgb = rgb;
    return r;
  endfunction

  function automatic req_t mk_lookup(logic [23:0] u, logic [23:0] v,
                                     logic [47:0] m0, logic [47:0] m1, logic [47:0] m2);
    req_t r;
    r.func = FUNC_LOOKUP;
    r.coord_u = u;
    r.coord_v = v;
    r.texel_addr = 16'($urandom);
    r.texel_rgb = 24'($urandom);
    r.rot_row0 = m0;
    r.rot_row1 = m1;
    r.rot_row2 = m2;
    return r;
  endfunction

  function automatic logic [47:0] rand_row(int kind);
    logic [47:0] m;
    m = 48'({$urandom, $urandom});
    if (kind == 1)
      for (int j = 0; j < 3; j++) m[47-16*j -: 16] = 16'($signed($urandom_range(0, 32768)) - 16384);
    else if (kind == 2)
      m = '0;
    return m;
  endfunction

  task automatic send(req_t r, bit typed = 1'b0, rsp_t e = '0);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    n_items++;
    if (r.func == FUNC_WRITE) begin
      texel_mirror[int'(r.texel_addr)] = r.texel_rgb;
    end else begin
      normal_q.push_back(typed ? e : predict_normal(r));
    end
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (normal_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_cfg(logic [3:0] en, logic [3:0] wl, logic [3:0] hl);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAP_ENABLED;
    cfg_data <= {3'($urandom), en[0]};
    @(posedge clk);
    cfg_index <= CFG_WIDTH_LOG2;
    cfg_data <= wl;
    @(posedge clk);
    cfg_index <= CFG_HEIGHT_LOG2;
    cfg_data <= hl;
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data <= LOG2_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    map_on = en[0];
    width_reg = wl;
    height_reg = hl;
    n_config++;
  endtask

  function automatic req_t lookup_at(int col, int row, int kind);
    logic [23:0] u, v;
    int wl, hl, vrow;
    wl = side_log2(width_reg);
    hl = side_log2(height_reg);
    vrow = (1 << hl) - 1 - row;
    u = 24'($urandom);
    v = 24'($urandom);
    for (int b = 0; b < wl; b++) u[16-wl+b] = col[b];
    for (int b = 0; b < hl; b++) v[16-hl+b] = vrow[b];
    return mk_lookup(u, v, rand_row(kind), rand_row(kind), rand_row(kind));
  endfunction

  task automatic random_phase(int count);
    int wl, hl, col, row, addr, pick;
    req_t r;
    wl = side_log2(width_reg);
    hl = side_log2(height_reg);
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send(mk_write($urandom_range(0, 65535), 24'($urandom)));
      end else begin
        col = $urandom_range(0, (1 << wl) - 1);
        row = $urandom_range(0, (1 << hl) - 1);
        addr = ((row << wl) + col) & 16'hFFFF;
        if (!texel_mirror.exists(addr) || pick < 30)
          send(mk_write(addr, 24'($urandom)));
        pick = $urandom_range(99);
        r = lookup_at(col, row, (pick < 45) ? 0 : (pick < 85) ? 1 : (pick < 92) ? 2 : 3);
        if (pick >= 92) begin
          r.rot_row1 = '0;
          r.rot_row2 = '0;
        end
        send(r);
      end
    end
  endtask

  always @(posedge clk) begin
    rsp_t e;
    if (rsp_valid && !rsp_stall) begin
      if (normal_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, rsp);
        errors++;
      end else begin
        e = normal_q.pop_front();
        n_normals++;
        if (rsp.degenerate) n_degen++;
        if (rsp.normal_x !== e.normal_x) begin
          $display("%0t: normal_x expected %0d actual %0d", $time, e.normal_x, rsp.normal_x);
          errors++;
        end
        if (rsp.normal_y !== e.normal_y) begin
          $display("%0t: normal_y expected %0d actual %0d", $time, e.normal_y, rsp.normal_y);
          errors++;
        end
        if (rsp.normal_z !== e.normal_z) begin
          $display("%0t: normal_z expected %0d actual %0d", $time, e.normal_z, rsp.normal_z);
          errors++;
        end
        if (rsp.degenerate !== e.degenerate) begin
          $display("%0t: degenerate expected %b actual %b", $time, e.degenerate, rsp.degenerate);
          errors++;
        end
      end
    end
    if (long_hold && !hold_used) begin
      hold_used = 1'b1;
      hold_cnt = LONG_HOLD;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  initial begin
    #2ms;
    $display("FAIL normal_map_sample_rotate_top");
    $finish;
  end

  initial begin
    stim_row_t plan [$];
    stim_row_t sr;
    logic [47:0] ident0, ident1, ident2, xpos, xneg;
    rsp_t zero_n, degen_n, xpos_n, xneg_n;
    logic [3:0] cfgs [8][3];
    ident0 = {16'h4000, 16'h0000, 16'h0000};
    ident1 = {16'h0000, 16'h4000, 16'h0000};
    ident2 = {16'h0000, 16'h0000, 16'h4000};
    xpos = {16'h4000, 32'h0};
    xneg = {16'hC000, 32'h0};
    zero_n = '0;
    degen_n = '0;
    degen_n.degenerate = 1'b1;
    xpos_n = '0;
    xpos_n.normal_x = 16'sd16384;
    xneg_n = '0;
    xneg_n.normal_x = -16'sd16384;

    sr = '{ROW_ITEM, mk_write(16'hFFFF, 24'hFFFFFF), 0, zero_n, 0, 0, 0};
    plan.push_back(sr);
    sr = '{ROW_ITEM, mk_lookup(24'h00FF00, 24'h0, ident0, ident1, ident2), 1, zero_n, 0, 0, 0};
    plan.push_back(sr);
    sr = '{ROW_CFG, '0, 0, zero_n, 4'd1, 4'd8, 4'd8};
    plan.push_back(sr);
    sr = '{ROW_ITEM, mk_lookup(24'hFFFF00, 24'hFF0000, ident0, ident1, ident2), 0, zero_n, 0, 0, 0};
    plan.push_back(sr);
    sr = '{ROW_ITEM, mk_lookup(24'h00FF00, 24'h0, 48'h0, 48'h0, 48'h0), 1, degen_n, 0, 0, 0};
    plan.push_back(sr);
    sr = '{ROW_ITEM, mk_lookup(24'h00FF00, 24'h0, xpos, 48'h0, 48'h0), 1, xpos_n, 0, 0, 0};
    plan.push_back(sr);
    sr = '{ROW_ITEM, mk_lookup(24'h00FF00, 24'h0, xneg, 48'h0, 48'h0), 1, xneg_n, 0, 0, 0};
    plan.push_back(sr);
    sr = '{ROW_ITEM, mk_write(16'h0000, 24'h000000), 0, zero_n, 0, 0, 0};
    plan.push_back(sr);
    sr = '{ROW_ITEM, mk_lookup(24'hFF0000, 24'hFFFFFF, ident0, ident1, ident2), 0, zero_n, 0, 0, 0};
    plan.push_back(sr);
    sr = '{ROW_ITEM, mk_lookup(24'hFF0000, 24'hFFFFFF, {3{16'h7FFF}}, {3{16'h7FFF}},
                               {3{16'h7FFF}}), 0, zero_n, 0, 0, 0};
    plan.push_back(sr);
    sr = '{ROW_ITEM, mk_lookup(24'h00FF00, 24'h000000, {3{16'h8000}}, {3{16'h8000}},
                               {3{16'h8000}}), 0, zero_n, 0, 0, 0};
    plan.push_back(sr);
    sr = '{ROW_ITEM, mk_write(16'h1234, 24'h80FF01), 0, zero_n, 0, 0, 0};
    plan.push_back(sr);
    sr = '{ROW_ITEM, mk_lookup(24'h003400, 24'h00ED00, rand_row(0), rand_row(0), rand_row(0)),
           0, zero_n, 0, 0, 0};
    plan.push_back(sr);
    sr = '{ROW_CFG, '0, 0, zero_n, 4'd1, 4'd15, 4'd0};
    plan.push_back(sr);
    sr = '{ROW_ITEM, mk_write(16'h00FF, 24'h01807F), 0, zero_n, 0, 0, 0};
    plan.push_back(sr);
    sr = '{ROW_ITEM, mk_lookup(24'hABFF12, 24'h5A5A5A, ident0, ident1, ident2), 0, zero_n, 0, 0, 0};
    plan.push_back(sr);
    sr = '{ROW_CFG, '0, 0, zero_n, 4'd1, 4'd0, 4'd0};
    plan.push_back(sr);
    sr = '{ROW_ITEM, mk_lookup(24'hFFFFFF, 24'hFFFFFF, ident1, ident2, ident0), 0, zero_n, 0, 0, 0};
    plan.push_back(sr);

    cfgs = '{'{1, 8, 8}, '{1, 3, 5}, '{0, 4, 4}, '{1, 0, 8},
             '{1, 8, 0}, '{1, 15, 15}, '{1, 1, 1}, '{1, 2, 7}};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) set_cfg(plan[i].en, plan[i].wl, plan[i].hl);
      else send(plan[i].r, plan[i].typed, plan[i].e);
    end

    for (int p = 0; p < 8; p++) begin
      set_cfg(cfgs[p][0], cfgs[p][1], cfgs[p][2]);
      if (p == 3) begin
        snd_idle_pct = 86;
        rcv_idle_pct = 20;
      end else if (p == 6) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        long_hold = 1'b1;
      end
      random_phase(115);
    end

    wait_idle();
    $display("Covered %0d transactions over %0d register settings: %0d normals checked, %0d degenerate.",
             n_items, n_config, n_normals, n_degen);
    if (errors == 0) begin
      $display("PASS normal_map_sample_rotate_top");
    end else begin
      $display("FAIL normal_map_sample_rotate_top");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/nmsr_pkg.sv
rtl/core/nmsr_texmem.sv
rtl/core/nmsr_rotate.sv
rtl/core/nmsr_norm.sv
rtl/core/normal_map_sample_rotate_top.sv
test/normal_map_sample_rotate_top_tb.sv
